### hdl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int NUM_CELLS   = COLUMNS * ROWS;
    localparam int SHIFT_CELLS = COLUMNS * (ROWS - 1);
    localparam int ADDR_W      = $clog2(NUM_CELLS);
    localparam int SWEEP_W     = $clog2(NUM_CELLS + 1);
    localparam int TAB_STOP    = 8;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_BACK    = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [7:0] RESET_COLOR = 8'h07;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_SCROLL,
        ST_RESP
    } state_t;

endpackage

### hdl/text_console_writer_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, char_code, cell_index
// result    out        out_valid / out_stall cell_char, cell_color, cursor_row,
//                                           cursor_col, scrolled
// config    in         cfg_valid / cfg_ready cfg_data (text color)
//
// One item at a time. A read passes through a memory read state, skipped when
// out of range. Clear writes one cell per cycle. A put that scrolls shifts the
// grid up one row through the cell memory's one read and one write port.
// After reset a clearing pass fills the grid; no transfer is taken meanwhile,
// config writes are.
// A result waits in the output register while out_stall is high.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_color,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    state_t               state_reg, state_next;
    logic [SWEEP_W-1:0]   sweep_reg, sweep_next;
    logic [4:0]           row_reg, row_next;
    logic [6:0]           col_reg, col_next;
    logic [7:0]           text_color_reg;
    logic [7:0]           fill_color_reg, fill_color_next;
    logic [7:0]           res_char_reg, res_char_next;
    logic [7:0]           res_color_reg, res_color_next;
    logic                 res_scroll_reg, res_scroll_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic [7:0]           out_color_reg, out_color_next;
    logic [4:0]           out_row_reg, out_row_next;
    logic [6:0]           out_col_reg, out_col_next;
    logic                 out_scroll_reg, out_scroll_next;

    logic [15:0]          mem [NUM_CELLS];
    logic [15:0]          rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [15:0]          mem_wdata;

    logic                 newline;
    logic [7:0]           tab_col;
    logic [7:0]           col_inc;
    logic [5:0]           row_inc;
    logic [ADDR_W-1:0]    put_addr;
    logic [SWEEP_W-1:0]   sweep_prev;

    assign tab_col    = 8'(({1'b0, col_reg} / 8'(TAB_STOP) + 8'd1) * 8'(TAB_STOP));
    assign col_inc    = {1'b0, col_reg} + 8'd1;
    assign row_inc    = {1'b0, row_reg} + 6'd1;
    assign put_addr   = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign sweep_prev = sweep_reg - SWEEP_W'(1);

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cell_color = out_color_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign scrolled   = out_scroll_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            sweep_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            text_color_reg <= RESET_COLOR;
            fill_color_reg <= RESET_COLOR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            fill_color_reg <= fill_color_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                text_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_char_reg   <= res_char_next;
        res_color_reg  <= res_color_next;
        res_scroll_reg <= res_scroll_next;
        out_char_reg   <= out_char_next;
        out_color_reg  <= out_color_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_scroll_reg <= out_scroll_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        fill_color_next = fill_color_reg;
        res_char_next   = res_char_reg;
        res_color_next  = res_color_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        out_color_next  = out_color_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_scroll_next = out_scroll_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_reg[ADDR_W-1:0];
        mem_wdata       = {fill_color_reg, CH_SPACE};
        mem_raddr       = sweep_reg[ADDR_W-1:0];
        in_stall        = 1'b1;
        newline         = 1'b0;

        case (state_reg)
            ST_INIT, ST_FILL:
            begin
                mem_we = 1'b1;
                if (sweep_reg == SWEEP_W'(NUM_CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_RESP;
                end
                else
                begin
                    sweep_next = sweep_reg + SWEEP_W'(1);
                end
            end

            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    res_char_next   = '0;
                    res_color_next  = '0;
                    res_scroll_next = 1'b0;
                    state_next      = ST_RESP;
                    case (mode)
                        MODE_PUT:
                        begin
                            case (char_code)
                                CH_NEWLINE: newline = 1'b1;
                                CH_RETURN:  col_next = '0;
                                CH_BACK:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 7'd1;
                                    end
                                end
                                CH_TAB:
                                begin
                                    if (tab_col >= 8'(COLUMNS))
                                    begin
                                        newline = 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = tab_col[6:0];
                                    end
                                end
                                default:
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = put_addr;
                                    mem_wdata = {text_color_reg, char_code};
                                    if (col_inc >= 8'(COLUMNS))
                                    begin
                                        newline = 1'b1;
                                    end
                                    else
                                    begin
                                        col_next = col_inc[6:0];
                                    end
                                end
                            endcase
                            if (newline)
                            begin
                                col_next = '0;
                                if (row_inc >= 6'(ROWS))
                                begin
                                    row_next        = 5'(ROWS - 1);
                                    res_scroll_next = 1'b1;
                                    sweep_next      = '0;
                                    state_next      = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_inc[4:0];
                                end
                            end
                        end
                        MODE_READ:
                        begin
                            if (32'(cell_index) < NUM_CELLS)
                            begin
                                mem_raddr  = ADDR_W'(cell_index);
                                state_next = ST_READ;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            fill_color_next = text_color_reg;
                            sweep_next      = '0;
                            row_next        = '0;
                            col_next        = '0;
                            state_next      = ST_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_char_next  = rd_data_reg[7:0];
                res_color_next = rd_data_reg[15:8];
                state_next     = ST_RESP;
            end

            ST_SCROLL:
            begin
                // read one row ahead, write the cell read last cycle
                if (sweep_reg < SWEEP_W'(SHIFT_CELLS))
                begin
                    mem_raddr = ADDR_W'(32'(sweep_reg) + COLUMNS);
                end
                else if (sweep_reg == SWEEP_W'(NUM_CELLS))
                begin
                    mem_raddr = '0;
                end
                if (sweep_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = sweep_prev[ADDR_W-1:0];
                    if (sweep_prev >= SWEEP_W'(SHIFT_CELLS))
                    begin
                        mem_wdata = {rd_data_reg[15:8], CH_SPACE};
                    end
                    else
                    begin
                        mem_wdata = rd_data_reg;
                    end
                end
                if (sweep_reg == SWEEP_W'(NUM_CELLS))
                begin
                    sweep_next = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    sweep_next = sweep_reg + SWEEP_W'(1);
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = res_char_reg;
                    out_color_next  = res_color_reg;
                    out_row_next    = row_reg;
                    out_col_next    = col_reg;
                    out_scroll_next = res_scroll_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESP))
        else $error("result appeared outside response state");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_reg) < ROWS) && (32'(col_reg) < COLUMNS))
        else $error("cursor out of grid");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scrolled) |-> (32'(cursor_row) == ROWS - 1))
        else $error("scroll reported off the last row");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transfer taken while busy");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tcw_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 20_000_000;
    localparam int         ITEMS_PER_PHASE = 300;
    localparam int         NUM_PHASES  = 5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } console_cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_color;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic       scrolled;
    } cursor_report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    text_console_writer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // console shadow
    logic [15:0]    screen [0:NUM_CELLS-1];
    int             cur_row;
    int             cur_col;
    logic [7:0]     ink;

    console_cmd_t   cmd_q [$];
    cursor_report_t report_q [$];
    console_cmd_t   next_cmd;

    int accept_cnt;
    int offer_cnt;
    int taken_cnt;
    int stall_seen;
    int send_gap;
    int recv_wait;
    int errs;
    int cycle_cnt;
    bit send_steady;
    bit recv_steady;
    logic long_hold;

    function automatic logic advance_row();
        int i;
        cur_col = 0;
        if (cur_row + 1 >= ROWS) begin
            cur_row = ROWS - 1;
            for (i = 0; i < SHIFT_CELLS; i++)
                screen[i] = screen[i + COLUMNS];
            for (i = SHIFT_CELLS; i < NUM_CELLS; i++)
                screen[i][7:0] = CH_SPACE;
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic logic emit_byte(input logic [7:0] ch);
        int stop;
        case (ch)
            CH_NEWLINE: return advance_row();
            CH_RETURN:
            begin
                cur_col = 0;
                return 1'b0;
            end
            CH_BACK:
            begin
                if (cur_col > 0)
                    cur_col--;
                return 1'b0;
            end
            CH_TAB:
            begin
                stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
                if (stop >= COLUMNS)
                    return advance_row();
                cur_col = stop;
                return 1'b0;
            end
            default:
            begin
                screen[cur_row * COLUMNS + cur_col] = {ink, ch};
                cur_col++;
                if (cur_col >= COLUMNS)
                    return advance_row();
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void console_apply(input console_cmd_t c);
        cursor_report_t r;
        int i;
        r = '0;
        case (c.mode)
            MODE_PUT: r.scrolled = emit_byte(c.char_code);
            MODE_READ:
            begin
                if (c.cell_index < NUM_CELLS) begin
                    r.cell_char  = screen[c.cell_index][7:0];
                    r.cell_color = screen[c.cell_index][15:8];
                end
            end
            MODE_CLEAR:
            begin
                for (i = 0; i < NUM_CELLS; i++)
                    screen[i] = {ink, CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        r.cursor_row = cur_row[4:0];
        r.cursor_col = cur_col[6:0];
        report_q.push_back(r);
    endfunction

    task automatic push_cmd(input logic [1:0] m, input logic [7:0] ch,
                            input logic [10:0] idx);
        console_cmd_t c;
        c.mode       = m;
        c.char_code  = ch;
        c.cell_index = idx;
        cmd_q.push_back(c);
    endtask

    task automatic add_random(input int n, input bit allow_clear);
        int r;
        int k;
        logic [1:0]  m;
        logic [7:0]  ch;
        logic [10:0] idx;
        for (k = 0; k < n; k++) begin
            r   = $urandom_range(0, 99);
            ch  = 8'($urandom_range(0, 255));
            idx = 11'($urandom_range(0, 2047));
            if (r < 2)
                m = MODE_NONE;
            else if (r < 4)
                m = allow_clear ? MODE_CLEAR : MODE_READ;
            else if (r < 24) begin
                m = MODE_READ;
                r = $urandom_range(0, 9);
                if (r < 6)
                    idx = 11'($urandom_range(0, NUM_CELLS - 1));
                else if (r < 9)
                    idx = 11'($urandom_range(SHIFT_CELLS - 3 * COLUMNS, NUM_CELLS - 1));
            end else begin
                m = MODE_PUT;
                r = $urandom_range(0, 99);
                if (r < 10)
                    ch = CH_NEWLINE;
                else if (r < 17)
                    ch = CH_TAB;
                else if (r < 21)
                    ch = CH_RETURN;
                else if (r < 25)
                    ch = CH_BACK;
                else if (r < 85)
                    ch = 8'($urandom_range(8'h20, 8'h7E));
            end
            push_cmd(m, ch, idx);
        end
    endtask

    task automatic set_ink(input logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ink = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || accept_cnt != offer_cnt || report_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // long receiver hold-off so the core backs up and stalls its input
    initial
    begin
        long_hold = 1'b0;
        wait (accept_cnt >= 400);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && accept_cnt != offer_cnt)) begin
            if (in_valid) begin
                if ($urandom_range(0, 39) == 0)
                    send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 6);
            end
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                next_cmd = cmd_q.pop_front();
                in_valid   <= 1'b1;
                mode       <= next_cmd.mode;
                char_code  <= next_cmd.char_code;
                cell_index <= next_cmd.cell_index;
                offer_cnt++;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stall driver
    always @(negedge clk)
    begin
        if (taken_cnt != stall_seen) begin
            stall_seen = taken_cnt;
            if ($urandom_range(0, 39) == 0)
                recv_steady = !recv_steady;
            recv_wait = recv_steady ? 0 : $urandom_range(0, 6);
        end
        if (recv_wait > 0) begin
            out_stall <= 1'b1;
            if (out_valid)
                recv_wait--;
        end else begin
            out_stall <= long_hold;
        end
    end

    // monitor: result check first, then predict the accepted transfer
    always @(posedge clk)
    begin
        cursor_report_t want;
        console_cmd_t   got_cmd;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                taken_cnt++;
                if (report_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result transfer at cycle %0d", cycle_cnt);
                end else begin
                    want = report_q.pop_front();
                    if (cell_char !== want.cell_char || cell_color !== want.cell_color ||
                        cursor_row !== want.cursor_row || cursor_col !== want.cursor_col ||
                        scrolled !== want.scrolled) begin
                        errs++;
                        if (errs <= 10)
                            $display({"mismatch at cycle %0d: exp char %02h color %02h ",
                                      "row %0d col %0d scr %0b, got char %02h color %02h ",
                                      "row %0d col %0d scr %0b"},
                                     cycle_cnt, want.cell_char, want.cell_color,
                                     want.cursor_row, want.cursor_col, want.scrolled,
                                     cell_char, cell_color, cursor_row, cursor_col,
                                     scrolled);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                got_cmd.mode       = mode;
                got_cmd.char_code  = char_code;
                got_cmd.cell_index = cell_index;
                console_apply(got_cmd);
                accept_cnt++;
            end
        end
    end

    initial
    begin
        logic [7:0] phase_ink [NUM_PHASES];
        int p;
        int k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_PUT;
        char_code  = '0;
        cell_index = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        accept_cnt = 0;
        offer_cnt  = 0;
        taken_cnt  = 0;
        stall_seen = 0;
        send_gap   = 0;
        recv_wait  = 0;
        errs       = 0;
        cycle_cnt  = 0;
        ink        = RESET_COLOR;
        cur_row    = 0;
        cur_col    = 0;
        for (k = 0; k < NUM_CELLS; k++)
            screen[k] = {RESET_COLOR, CH_SPACE};

        phase_ink[0] = 8'hFF;
        phase_ink[1] = 8'h00;
        phase_ink[2] = 8'h1E;
        phase_ink[3] = 8'($urandom_range(0, 255));
        phase_ink[4] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reads at the edges, unused mode, control codes, tab wrap, clear
        push_cmd(MODE_READ, 8'h00, 11'd0);
        push_cmd(MODE_READ, 8'hFF, 11'(NUM_CELLS - 1));
        push_cmd(MODE_READ, 8'h00, 11'(NUM_CELLS));
        push_cmd(MODE_READ, 8'h00, 11'h7FF);
        push_cmd(MODE_NONE, 8'hFF, 11'h7FF);
        push_cmd(MODE_PUT, 8'h41, 11'd0);
        push_cmd(MODE_PUT, 8'h00, 11'd0);
        push_cmd(MODE_PUT, 8'hFF, 11'h7FF);
        for (k = 0; k < 4; k++)
            push_cmd(MODE_PUT, CH_BACK, 11'd0);
        push_cmd(MODE_PUT, 8'h78, 11'd0);
        push_cmd(MODE_PUT, CH_RETURN, 11'd0);
        for (k = 0; k < 10; k++)
            push_cmd(MODE_PUT, CH_TAB, 11'd0);
        push_cmd(MODE_PUT, CH_NEWLINE, 11'd0);
        push_cmd(MODE_READ, 8'h00, 11'd2);
        push_cmd(MODE_CLEAR, 8'h00, 11'd0);
        push_cmd(MODE_READ, 8'h00, 11'd0);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            set_ink(phase_ink[p]);
            add_random(ITEMS_PER_PHASE, p == 2 || p == 4);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (errs == 0 && report_q.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
hdl/tcw_pkg.sv
hdl/text_console_writer_core.sv
tb/tb_top.sv
